### rtl/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// Shared widths, constants, the CORDIC arctangent table and the stage payload
// types of the axis-angle view rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package avr_pkg;

  // Default CORDIC iteration count (valid range 8..24)
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Field widths
  localparam int ANG_W  = 16;   // angle, Q3.13
  localparam int AXIS_W = 16;   // axis component, Q1.14
  localparam int CRD_W  = 32;   // coordinate, Q16.16
  localparam int DIR_W  = 33;   // target - eye

  // Internal widths
  localparam int ZW_W      = 35;  // angle widened to Q30 before folding
  localparam int CZ_W      = 33;  // CORDIC angle accumulator
  localparam int CXY_W     = 33;  // CORDIC x / y, also c, s and 1-c
  localparam int PQ_W      = 32;  // axis products ap*aq
  localparam int SA_W      = 49;  // s * axis component
  localparam int TP_W      = 64;  // (1-c) * ap*aq
  localparam int ESUM_W    = 65;  // matrix entry sum in Q58
  localparam int ENT_W     = 31;  // matrix entry in Q24
  localparam int ENT_SHIFT = 34;
  localparam int PROD_W    = 64;  // entry * direction, Q40
  localparam int ACC_W     = 66;  // row sum in Q40
  localparam int RES_SHIFT = 24;
  localparam int RES_W     = ACC_W - RES_SHIFT;
  localparam int OSUM_W    = 43;  // eye + rotated direction

  // Angle handling
  localparam logic signed [ANG_W-1:0] ANG_MAX  = 16'sd25736;
  // smallest angle code whose Q30 value lies above pi/2
  localparam logic signed [ANG_W-1:0] FOLD_LIM = 16'sd12868;
  localparam int                      ANG_UP   = 17;
  localparam logic signed [ZW_W-1:0]  PI_Q30   = 35'sd3373259426;

  // CORDIC start value and unit
  localparam logic signed [CXY_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CXY_W-1:0] ONE_Q30      = 33'sd1073741824;
  localparam int                      DIAG_SHIFT   = 28;
  localparam int                      SIN_SHIFT    = 14;

  // Rounding offsets
  localparam logic signed [ESUM_W-1:0] ENT_RND = 65'sd8589934592;
  localparam logic signed [ACC_W-1:0]  RES_RND = 66'sd8388608;

  // Saturation bounds
  localparam logic signed [OSUM_W-1:0] SAT_MAX = 43'sd2147483647;
  localparam logic signed [OSUM_W-1:0] SAT_MIN = -43'sd2147483648;

  // atan(2^-i) in Q30
  function automatic logic signed [CZ_W-1:0] atan_q30(input int idx);
    logic signed [CZ_W-1:0] val;
    case (idx)
      0:       val = 33'sd843314857;
      1:       val = 33'sd497837829;
      2:       val = 33'sd263043837;
      3:       val = 33'sd133525159;
      4:       val = 33'sd67021687;
      5:       val = 33'sd33543516;
      6:       val = 33'sd16775851;
      7:       val = 33'sd8388437;
      8:       val = 33'sd4194283;
      9:       val = 33'sd2097149;
      10:      val = 33'sd1048576;
      11:      val = 33'sd524288;
      12:      val = 33'sd262144;
      13:      val = 33'sd131072;
      14:      val = 33'sd65536;
      15:      val = 33'sd32768;
      16:      val = 33'sd16384;
      17:      val = 33'sd8192;
      18:      val = 33'sd4096;
      19:      val = 33'sd2048;
      20:      val = 33'sd1024;
      21:      val = 33'sd512;
      22:      val = 33'sd256;
      23:      val = 33'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

  typedef logic signed [ENT_W-1:0] ment_t;

  // Request beat as taken from the port
  typedef struct packed {
    logic signed [ANG_W-1:0]  rot_angle;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [CRD_W-1:0]  eye_x;
    logic signed [CRD_W-1:0]  eye_y;
    logic signed [CRD_W-1:0]  eye_z;
    logic signed [CRD_W-1:0]  target_x;
    logic signed [CRD_W-1:0]  target_y;
    logic signed [CRD_W-1:0]  target_z;
  } req_t;

  // Geometry that rides alongside the CORDIC
  typedef struct packed {
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic signed [CRD_W-1:0]  ex;
    logic signed [CRD_W-1:0]  ey;
    logic signed [CRD_W-1:0]  ez;
    logic signed [DIR_W-1:0]  dx;
    logic signed [DIR_W-1:0]  dy;
    logic signed [DIR_W-1:0]  dz;
  } geom_t;

  // Front stage output: folded angle
  typedef struct packed {
    logic                    neg;
    logic signed [CZ_W-1:0]  z;
    geom_t                   geom;
  } front_t;

  // CORDIC output: raw cosine / sine before the fold correction
  typedef struct packed {
    logic                    neg;
    logic signed [CXY_W-1:0] x;
    logic signed [CXY_W-1:0] y;
    geom_t                   geom;
  } rot_t;

  // Matrix stage output
  typedef struct packed {
    ment_t [8:0]             m;
    logic signed [CRD_W-1:0] ex;
    logic signed [CRD_W-1:0] ey;
    logic signed [CRD_W-1:0] ez;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
  } mat_t;

  // Result beat
  typedef struct packed {
    logic signed [CRD_W-1:0] new_target_x;
    logic signed [CRD_W-1:0] new_target_y;
    logic signed [CRD_W-1:0] new_target_z;
    logic                    clipped;
  } res_t;

endpackage

`default_nettype wire

### rtl/avr_req_if.sv
// ----------------------------------------------------------------------------
// avr_req_if
// Request channel: rotation angle, axis, eye and target, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface avr_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_angle;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;

  modport source (
    output valid, rot_angle, axis_x, axis_y, axis_z,
    output eye_x, eye_y, eye_z, target_x, target_y, target_z,
    input  ready
  );

  modport sink (
    input  valid, rot_angle, axis_x, axis_y, axis_z,
    input  eye_x, eye_y, eye_z, target_x, target_y, target_z,
    output ready
  );
endinterface

`default_nettype wire

### rtl/avr_rsp_if.sv
// ----------------------------------------------------------------------------
// avr_rsp_if
// Result channel: rotated view point and saturation flag, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface avr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_target_x;
  logic signed [31:0] new_target_y;
  logic signed [31:0] new_target_z;
  logic               clipped;

  modport source (
    output valid, new_target_x, new_target_y, new_target_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, new_target_x, new_target_y, new_target_z, clipped,
    output ready
  );
endinterface

`default_nettype wire

### rtl/avr_front.sv
// ----------------------------------------------------------------------------
// avr_front
// Entry stage: clamps the angle, folds it into [-pi/2, pi/2] in Q30 and
// forms the view direction target - eye.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_front import avr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire req_t   in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output front_t      out_data
);

  logic                   vld;
  logic                   ld;
  logic signed [ANG_W-1:0] ang_c;
  logic signed [ZW_W-1:0]  z_wide;
  logic signed [ZW_W-1:0]  z_fold;
  front_t                  data_next;

  assign ld        = !vld || out_ready;
  assign in_ready  = ld;
  assign out_valid = vld;

  // Clamp, widen and fold the angle; subtract eye from target
  always_comb begin
    ang_c = in_data.rot_angle;
    if (in_data.rot_angle > ANG_MAX) begin
      ang_c = ANG_MAX;
    end else if (in_data.rot_angle < -ANG_MAX) begin
      ang_c = -ANG_MAX;
    end
    z_wide = ZW_W'(ang_c) <<< ANG_UP;
    data_next.neg = 1'b0;
    z_fold = z_wide;
    if (ang_c >= FOLD_LIM) begin
      z_fold        = z_wide - PI_Q30;
      data_next.neg = 1'b1;
    end else if (ang_c <= -FOLD_LIM) begin
      z_fold        = z_wide + PI_Q30;
      data_next.neg = 1'b1;
    end
    data_next.z       = z_fold[CZ_W-1:0];
    data_next.geom.ax = in_data.axis_x;
    data_next.geom.ay = in_data.axis_y;
    data_next.geom.az = in_data.axis_z;
    data_next.geom.ex = in_data.eye_x;
    data_next.geom.ey = in_data.eye_y;
    data_next.geom.ez = in_data.eye_z;
    data_next.geom.dx = DIR_W'(in_data.target_x) - DIR_W'(in_data.eye_x);
    data_next.geom.dy = DIR_W'(in_data.target_y) - DIR_W'(in_data.eye_y);
    data_next.geom.dz = DIR_W'(in_data.target_z) - DIR_W'(in_data.eye_z);
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ld) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

### rtl/avr_cordic.sv
// ----------------------------------------------------------------------------
// avr_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Produces cos and sin of the folded angle in Q30; geometry rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_cordic import avr_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire front_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output rot_t        out_data
);

  // iterations past the end of the arctangent table are not run
  localparam int NS = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

  // index 0 is the stage input, index k+1 the register after step k
  logic                    vld [0:NS];
  logic [NS:0]             ld;
  logic signed [CXY_W-1:0] xs  [0:NS];
  logic signed [CXY_W-1:0] ys  [0:NS];
  logic signed [CZ_W-1:0]  zs  [0:NS];
  logic                    ngs [0:NS];
  geom_t                   geo [0:NS];

  assign vld[0] = in_valid;
  assign xs[0]  = INV_GAIN_Q30;
  assign ys[0]  = '0;
  assign zs[0]  = in_data.z;
  assign ngs[0] = in_data.neg;
  assign geo[0] = in_data.geom;

  assign ld[NS]   = out_ready;
  assign in_ready = ld[0];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_step
      // a stage loads when it is empty or its content moves on
      assign ld[k] = !vld[k+1] || ld[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (ld[k]) begin
          vld[k+1] <= vld[k];
        end
      end

      // micro-rotation k: direction from the sign of the residual angle
      always_ff @(posedge clk) begin
        if (ld[k]) begin
          if (!zs[k][CZ_W-1]) begin
            xs[k+1] <= xs[k] - (ys[k] >>> k);
            ys[k+1] <= ys[k] + (xs[k] >>> k);
            zs[k+1] <= zs[k] - atan_q30(k);
          end else begin
            xs[k+1] <= xs[k] + (ys[k] >>> k);
            ys[k+1] <= ys[k] - (xs[k] >>> k);
            zs[k+1] <= zs[k] + atan_q30(k);
          end
          ngs[k+1] <= ngs[k];
          geo[k+1] <= geo[k];
        end
      end
    end
  endgenerate

  assign out_valid     = vld[NS];
  assign out_data.neg  = ngs[NS];
  assign out_data.x    = xs[NS];
  assign out_data.y    = ys[NS];
  assign out_data.geom = geo[NS];

endmodule

`default_nettype wire

### rtl/avr_matrix.sv
// ----------------------------------------------------------------------------
// avr_matrix
// Builds the Rodrigues matrix c*I + (1-c)*a*a^T + s*[a]x in Q24 over four
// stages: fold correction and axis products, 1-c and s*a, (1-c)*a*a^T,
// then the rounded entry sums.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_matrix import avr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire rot_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output mat_t      out_data
);

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] ld;

  // stage 1
  logic signed [CXY_W-1:0] c1;
  logic signed [CXY_W-1:0] s1;
  logic signed [PQ_W-1:0]  pq1 [0:5];
  geom_t                   g1;
  // stage 2
  logic signed [CXY_W-1:0] c2;
  logic signed [CXY_W-1:0] t2;
  logic signed [PQ_W-1:0]  pq2 [0:5];
  logic signed [SA_W-1:0]  sa2 [0:2];
  geom_t                   g2;
  // stage 3
  logic signed [CXY_W-1:0] c3;
  logic signed [TP_W-1:0]  tp3 [0:5];
  logic signed [SA_W-1:0]  sa3 [0:2];
  geom_t                   g3;
  // entry sums
  logic signed [ESUM_W-1:0] cb;
  logic signed [ESUM_W-1:0] tpw [0:5];
  logic signed [ESUM_W-1:0] saw [0:2];
  mat_t                     mat_next;

  // Round a Q58 sum to Q24
  function automatic ment_t ent_round(input logic signed [ESUM_W-1:0] sum);
    logic signed [ESUM_W-1:0] r;
    r = sum + ENT_RND;
    return r[ESUM_W-1:ENT_SHIFT];
  endfunction

  // Ready chain
  assign ld[NST-1] = !vld[NST-1] || out_ready;
  assign ld[2]     = !vld[2] || ld[3];
  assign ld[1]     = !vld[1] || ld[2];
  assign ld[0]     = !vld[0] || ld[1];
  assign in_ready  = ld[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      if (ld[1]) vld[1] <= vld[0];
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
    end
  end

  // Stage 1: undo the fold on c and s; axis outer products
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      c1     <= in_data.neg ? -in_data.x : in_data.x;
      s1     <= in_data.neg ? -in_data.y : in_data.y;
      pq1[0] <= in_data.geom.ax * in_data.geom.ax;
      pq1[1] <= in_data.geom.ax * in_data.geom.ay;
      pq1[2] <= in_data.geom.ax * in_data.geom.az;
      pq1[3] <= in_data.geom.ay * in_data.geom.ay;
      pq1[4] <= in_data.geom.ay * in_data.geom.az;
      pq1[5] <= in_data.geom.az * in_data.geom.az;
      g1     <= in_data.geom;
    end
  end

  // Stage 2: t = 1 - c; s times each axis component
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      c2     <= c1;
      t2     <= ONE_Q30 - c1;
      pq2    <= pq1;
      sa2[0] <= SA_W'(s1) * SA_W'(g1.ax);
      sa2[1] <= SA_W'(s1) * SA_W'(g1.ay);
      sa2[2] <= SA_W'(s1) * SA_W'(g1.az);
      g2     <= g1;
    end
  end

  // Stage 3: t times each axis product
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      c3  <= c2;
      for (int i = 0; i < 6; i++) begin
        tp3[i] <= TP_W'(t2) * TP_W'(pq2[i]);
      end
      sa3 <= sa2;
      g3  <= g2;
    end
  end

  // Stage 4: combine into the nine entries and round
  always_comb begin
    cb = ESUM_W'(c3) <<< DIAG_SHIFT;
    for (int i = 0; i < 6; i++) begin
      tpw[i] = ESUM_W'(tp3[i]);
    end
    for (int i = 0; i < 3; i++) begin
      saw[i] = ESUM_W'(sa3[i]) <<< SIN_SHIFT;
    end
    // sa index: 0 = s*ax, 1 = s*ay, 2 = s*az
    mat_next.m[0] = ent_round(cb + tpw[0]);
    mat_next.m[1] = ent_round(tpw[1] - saw[2]);
    mat_next.m[2] = ent_round(tpw[2] + saw[1]);
    mat_next.m[3] = ent_round(tpw[1] + saw[2]);
    mat_next.m[4] = ent_round(cb + tpw[3]);
    mat_next.m[5] = ent_round(tpw[4] - saw[0]);
    mat_next.m[6] = ent_round(tpw[2] - saw[1]);
    mat_next.m[7] = ent_round(tpw[4] + saw[0]);
    mat_next.m[8] = ent_round(cb + tpw[5]);
    mat_next.ex   = g3.ex;
    mat_next.ey   = g3.ey;
    mat_next.ez   = g3.ez;
    mat_next.dx   = g3.dx;
    mat_next.dy   = g3.dy;
    mat_next.dz   = g3.dz;
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      out_data <= mat_next;
    end
  end

endmodule

`default_nettype wire

### rtl/avr_apply.sv
// ----------------------------------------------------------------------------
// avr_apply
// Rotates the direction by the matrix and adds the eye back: products,
// rounded row sums, then the saturating add into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_apply import avr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mat_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  localparam int NST = 3;

  logic [NST-1:0] vld;
  logic [NST-1:0] ld;

  logic signed [PROD_W-1:0] p1 [0:8];
  logic signed [CRD_W-1:0]  e1 [0:2];
  logic signed [ACC_W-1:0]  acc [0:2];
  logic signed [RES_W-1:0]  r2 [0:2];
  logic signed [CRD_W-1:0]  e2 [0:2];
  logic signed [OSUM_W-1:0] osum [0:2];
  logic signed [CRD_W-1:0]  sat [0:2];
  logic [2:0]               clip;

  // Ready chain
  assign ld[2]     = !vld[2] || out_ready;
  assign ld[1]     = !vld[1] || ld[2];
  assign ld[0]     = !vld[0] || ld[1];
  assign in_ready  = ld[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      if (ld[1]) vld[1] <= vld[0];
      if (ld[2]) vld[2] <= vld[1];
    end
  end

  // Stage 1: entry times direction component, Q40
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int r = 0; r < 3; r++) begin
        p1[3*r]   <= PROD_W'(in_data.m[3*r])   * PROD_W'(in_data.dx);
        p1[3*r+1] <= PROD_W'(in_data.m[3*r+1]) * PROD_W'(in_data.dy);
        p1[3*r+2] <= PROD_W'(in_data.m[3*r+2]) * PROD_W'(in_data.dz);
      end
      e1[0] <= in_data.ex;
      e1[1] <= in_data.ey;
      e1[2] <= in_data.ez;
    end
  end

  // Stage 2: row sums rounded to Q16
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_W'(p1[3*r]) + ACC_W'(p1[3*r+1]) + ACC_W'(p1[3*r+2]) + RES_RND;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int r = 0; r < 3; r++) begin
        r2[r] <= acc[r][ACC_W-1:RES_SHIFT];
      end
      e2 <= e1;
    end
  end

  // Stage 3: add eye and clamp to 32 bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      osum[r] = OSUM_W'(e2[r]) + OSUM_W'(r2[r]);
      sat[r]  = osum[r][CRD_W-1:0];
      clip[r] = 1'b0;
      if (osum[r] > SAT_MAX) begin
        sat[r]  = SAT_MAX[CRD_W-1:0];
        clip[r] = 1'b1;
      end else if (osum[r] < SAT_MIN) begin
        sat[r]  = SAT_MIN[CRD_W-1:0];
        clip[r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      out_data.new_target_x <= sat[0];
      out_data.new_target_y <= sat[1];
      out_data.new_target_z <= sat[2];
      out_data.clipped      <= |clip;
    end
  end

endmodule

`default_nettype wire

### rtl/axis_angle_view_rotator_top.sv
// ----------------------------------------------------------------------------
// axis_angle_view_rotator_top
// Rotates a camera's view point about a unit axis through the eye.
// ----------------------------------------------------------------------------
// Each request beat gives an angle (Q3.13 radians, clamped to +/-pi), a unit
// axis (Q1.14) and the eye and target points (Q16.16). The block returns
// eye + R*(target - eye), with R the axis-angle rotation matrix built from a
// CORDIC cosine and sine, saturated to 32 bits with clipped set when any
// component was clamped. The datapath is a single pipeline that accepts one
// beat per clock unless stalled, with one entry stage, one CORDIC stage per
// iteration, four matrix stages and three rotate-and-add stages; CORDIC_STEPS
// (8..24) is the only term that changes the stage count. Every stage holds a
// valid bit and moves only when the stage after it is empty or moving, so
// back-pressure on the result port stalls without loss and bubbles are
// squeezed out. There is no state between beats and nothing to configure.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_view_rotator_top import avr_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  avr_req_if.sink    rot_req,
  avr_rsp_if.source  rot_rsp
);

  req_t   req;
  logic   fr_valid;
  logic   fr_ready;
  front_t fr_data;
  logic   cd_valid;
  logic   cd_ready;
  rot_t   cd_data;
  logic   mx_valid;
  logic   mx_ready;
  mat_t   mx_data;
  res_t   res;

  // Gather the request beat
  always_comb begin
    req.rot_angle = rot_req.rot_angle;
    req.axis_x    = rot_req.axis_x;
    req.axis_y    = rot_req.axis_y;
    req.axis_z    = rot_req.axis_z;
    req.eye_x     = rot_req.eye_x;
    req.eye_y     = rot_req.eye_y;
    req.eye_z     = rot_req.eye_z;
    req.target_x  = rot_req.target_x;
    req.target_y  = rot_req.target_y;
    req.target_z  = rot_req.target_z;
  end

  avr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_req.valid),
    .in_ready  (rot_req.ready),
    .in_data   (req),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  avr_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (cd_valid),
    .out_ready (cd_ready),
    .out_data  (cd_data)
  );

  avr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cd_valid),
    .in_ready  (cd_ready),
    .in_data   (cd_data),
    .out_valid (mx_valid),
    .out_ready (mx_ready),
    .out_data  (mx_data)
  );

  avr_apply u_apply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mx_valid),
    .in_ready  (mx_ready),
    .in_data   (mx_data),
    .out_valid (rot_rsp.valid),
    .out_ready (rot_rsp.ready),
    .out_data  (res)
  );

  // Result beat
  assign rot_rsp.new_target_x = res.new_target_x;
  assign rot_rsp.new_target_y = res.new_target_y;
  assign rot_rsp.new_target_z = res.new_target_z;
  assign rot_rsp.clipped      = res.clipped;

endmodule

`default_nettype wire
